FILE: src/sscr_pkg.sv
// Shared constants and helper functions for the seven-segment clock raster.
// Holds canvas geometry, the segment code table and the decimal digit split.
// No dependencies.
package sscr_pkg;

  localparam int CanvasW   = 182;
  localparam int CanvasH   = 68;
  localparam int DigitW    = 32;
  localparam int BarThick  = 6;
  localparam int HBarLen   = 28;
  localparam int VBarLen   = 25;
  localparam int DotSize   = 8;
  localparam int DotX      = 82;
  localparam int DotTopY   = 16;
  localparam int DotBotY   = 36;
  localparam int NumCells  = 4;

  // Left edge of each digit cell: hours tens, hours ones, minutes tens, minutes ones.
  localparam logic [7:0] CELL_X [NumCells] = '{8'd0, 8'd40, 8'd100, 8'd140};

  // Segment bit positions within a segment code (a is the top bit).
  localparam int SegA = 6;
  localparam int SegB = 5;
  localparam int SegC = 4;
  localparam int SegD = 3;
  localparam int SegE = 2;
  localparam int SegF = 1;
  localparam int SegG = 0;

  typedef logic [6:0] seg_code_t;
  typedef logic [3:0] digit_t;

  // Seven-segment pattern for a decimal digit; codes above nine light nothing.
  function automatic seg_code_t seg_code(digit_t digit);
    seg_code_t s;
    case (digit)
      4'd0:    s = 7'b1111110;
      4'd1:    s = 7'b0110000;
      4'd2:    s = 7'b1101101;
      4'd3:    s = 7'b1111001;
      4'd4:    s = 7'b0110011;
      4'd5:    s = 7'b1011011;
      4'd6:    s = 7'b1011111;
      4'd7:    s = 7'b1110000;
      4'd8:    s = 7'b1111111;
      4'd9:    s = 7'b1111011;
      default: s = 7'b0000000;
    endcase
    return s;
  endfunction

  // Tens digit of a 7-bit value by reciprocal multiply (exact for all 7-bit values).
  function automatic digit_t tens_digit(logic [6:0] value);
    logic [14:0] prod;
    prod = 15'(value) * 15'd205;
    return digit_t'(prod[14:11]);
  endfunction

  function automatic digit_t ones_digit(logic [6:0] value, digit_t tens);
    logic [6:0] tens_x10;
    tens_x10 = {tens, 3'b000} - 7'(tens) - 7'(tens) + 7'(tens) + 7'(tens) + {2'b00, tens, 1'b0};
    return digit_t'(value - tens_x10);
  endfunction

  // End indent of a bar for offset k across it: 3,2,1,1,2,3.
  function automatic logic [1:0] taper(logic [2:0] k);
    logic [1:0] d;
    case (k)
      3'd0, 3'd5: d = 2'd3;
      3'd1, 3'd4: d = 2'd2;
      default:    d = 2'd1;
    endcase
    return d;
  endfunction

  // Tapered bar test on 8-bit coordinates.
  function automatic logic bar_hit(logic [7:0] across, logic [7:0] across_start,
                                   logic [7:0] along, logic [7:0] along_start,
                                   logic [7:0] len);
    logic [7:0] k;
    logic [7:0] d;
    k = across - across_start;
    d = 8'(taper(k[2:0]));
    return (across >= across_start) && (across < across_start + 8'(BarThick)) &&
           (along >= along_start + d) && (along <= along_start + len - d);
  endfunction

endpackage

FILE: src/sscr_cell.sv
// One digit cell: decides whether a cell-local pixel lies on a lit segment.
// Depends on sscr_pkg for the segment table and bar geometry.
module sscr_cell import sscr_pkg::*; (
  input  digit_t     digit,
  input  logic [4:0] lx,
  input  logic [6:0] py,
  output logic       dark
);

  seg_code_t  seg;
  logic [7:0] x8;
  logic [7:0] y8;
  logic [7:0] right_x;

  assign seg     = seg_code(digit);
  assign x8      = 8'(lx);
  assign y8      = 8'(py);
  assign right_x = 8'(DigitW - BarThick);

  always_comb begin
    dark = 1'b0;
    if (seg[SegA] && bar_hit(y8, 8'd0, x8, 8'd2, 8'(HBarLen)))    dark = 1'b1;
    if (seg[SegB] && bar_hit(x8, right_x, y8, 8'd5, 8'(VBarLen)))  dark = 1'b1;
    if (seg[SegC] && bar_hit(x8, right_x, y8, 8'd32, 8'(VBarLen))) dark = 1'b1;
    if (seg[SegD] && bar_hit(y8, 8'd54, x8, 8'd2, 8'(HBarLen)))   dark = 1'b1;
    if (seg[SegE] && bar_hit(x8, 8'd0, y8, 8'd32, 8'(VBarLen)))    dark = 1'b1;
    if (seg[SegF] && bar_hit(x8, 8'd0, y8, 8'd5, 8'(VBarLen)))     dark = 1'b1;
    if (seg[SegG] && bar_hit(y8, 8'd27, x8, 8'd2, 8'(HBarLen)))   dark = 1'b1;
  end

endmodule

FILE: src/sscr_raster.sv
// Pixel classifier: splits the time into digits, places four cells and the colon.
// Depends on sscr_pkg and sscr_cell.
module sscr_raster import sscr_pkg::*; (
  input  logic [7:0] pixel_x,
  input  logic [6:0] pixel_y,
  input  logic [6:0] hours_value,
  input  logic [6:0] minutes_value,
  input  logic       colon_on,
  output logic       pixel_dark
);

  digit_t              digits [NumCells];
  logic [NumCells-1:0] cell_dark;
  logic                in_canvas;
  logic                in_colon;

  assign digits[0] = tens_digit(hours_value);
  assign digits[1] = ones_digit(hours_value, digits[0]);
  assign digits[2] = tens_digit(minutes_value);
  assign digits[3] = ones_digit(minutes_value, digits[2]);

  for (genvar i = 0; i < NumCells; i++) begin : g_cell
    logic [7:0] lx_full;
    logic       in_cell;
    logic       hit;

    assign lx_full = pixel_x - CELL_X[i];
    assign in_cell = (pixel_x >= CELL_X[i]) && (pixel_x < CELL_X[i] + 8'(DigitW));

    sscr_cell u_cell (
      .digit (digits[i]),
      .lx    (lx_full[4:0]),
      .py    (pixel_y),
      .dark  (hit)
    );

    assign cell_dark[i] = in_cell && hit;
  end

  assign in_canvas = (pixel_x < 8'(CanvasW)) && (pixel_y < 7'(CanvasH));
  assign in_colon  = (pixel_x >= 8'(DotX)) && (pixel_x < 8'(DotX + DotSize)) &&
                     (((pixel_y >= 7'(DotTopY)) && (pixel_y < 7'(DotTopY + DotSize))) ||
                      ((pixel_y >= 7'(DotBotY)) && (pixel_y < 7'(DotBotY + DotSize))));

  assign pixel_dark = in_canvas && ((|cell_dark) || (colon_on && in_colon));

endmodule

FILE: src/seven_segment_clock_pixel_raster.sv
// Top level of the seven-segment clock raster: input register, classifier, result register.
// Depends on sscr_pkg and sscr_raster.
//
// Usage: drive one pixel query per transfer on the s_axis channel; each query
// yields exactly one result transfer on the m_axis channel, in order.
// s_axis_tdata carries the coordinate and the time to show; m_axis_tdata bit 0
// says whether that pixel is dark (black segment or colon) or white.
// Path: a query accepted on s_axis is held in the input register, then moves
// into the result register and is offered on m_axis from there; a stall on
// m_axis can keep it in the input register in between.
// Throughput: one query per cycle while m_axis_tready is high, set by the
// combinational classifier between the input register and the result register.
// Stall: when m_axis_tready is low the result register holds; the input
// register keeps accepting until it too holds an item, then s_axis_tready
// drops. No item is lost or repeated.
// Reset: rst empties both registers; the block holds no other state and
// raises s_axis_tready as soon as reset is released.
module seven_segment_clock_pixel_raster import sscr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [7:0] pixel_x, [14:8] pixel_y, [21:15] hours_value, [28:22] minutes_value,
  // [29] colon_on, [31:30] zero
  input  logic [31:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] pixel_dark, [7:1] zero
  output logic [7:0]  m_axis_tdata
);

  logic        in_valid;
  logic [7:0]  in_x;
  logic [6:0]  in_y;
  logic [6:0]  in_hours;
  logic [6:0]  in_minutes;
  logic        in_colon;
  logic        out_valid;
  logic        out_dark;
  logic        dark_next;
  logic        out_advance;
  logic        in_advance;

  assign out_advance   = !out_valid || m_axis_tready;
  assign in_advance    = !in_valid || out_advance;
  assign s_axis_tready = in_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_advance) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_advance && s_axis_tvalid) begin
      in_x       <= s_axis_tdata[7:0];
      in_y       <= s_axis_tdata[14:8];
      in_hours   <= s_axis_tdata[21:15];
      in_minutes <= s_axis_tdata[28:22];
      in_colon   <= s_axis_tdata[29];
    end
  end

  sscr_raster u_raster (
    .pixel_x       (in_x),
    .pixel_y       (in_y),
    .hours_value   (in_hours),
    .minutes_value (in_minutes),
    .colon_on      (in_colon),
    .pixel_dark    (dark_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_advance) begin
      out_valid <= in_valid;
    end
  end

  // Capture a result only when a query moves into the result register.
  always_ff @(posedge clk) begin
    if (out_advance && in_valid) begin
      out_dark <= dark_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {7'b0, out_dark};

`ifndef SYNTHESIS
  a_query_reaches_output: assert property (@(posedge clk) disable iff (rst)
    in_valid && out_advance |=> m_axis_tvalid)
    else $error("query in input register did not reach the result register");

  a_stall_holds_input: assert property (@(posedge clk) disable iff (rst)
    in_valid && m_axis_tvalid && !m_axis_tready |=> in_valid && $stable(in_x))
    else $error("input register changed while downstream stalled");

  a_off_canvas_white: assert property (@(posedge clk) disable iff (rst)
    in_valid && out_advance && (in_x >= 8'(CanvasW)) |=> !m_axis_tdata[0])
    else $error("pixel outside the canvas reported dark");
`endif

endmodule
